// ===== rtl/fph_pkg.sv =====
// fph_pkg: shared types and constants of the flow header parser
// no dependencies; used by fph_parse and packet_flow_header_parser
package fph_pkg;

  localparam int unsigned OFFSET_BITS = 17;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [1:0] MAX_VLAN_TAGS   = 2'd2;
  localparam logic [2:0] MAX_EXT_HEADERS = 3'd6;

  // parse status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  // ethertypes
  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_QINQ  = 16'h88a8;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_IPV6  = 16'h86dd;

  // ip protocol numbers
  localparam logic [7:0] PROTO_HOPOPT = 8'd0;
  localparam logic [7:0] PROTO_ROUTE  = 8'd43;
  localparam logic [7:0] PROTO_FRAG   = 8'd44;
  localparam logic [7:0] PROTO_AH     = 8'd51;
  localparam logic [7:0] PROTO_DSTOPT = 8'd60;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;

  localparam logic [15:0] V4_FRAG_MASK = 16'h1fff;
  localparam logic [15:0] V6_FRAG_MASK = 16'hfff8;

  // one flow record
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  family;
    logic [7:0]  proto;
    logic [7:0]  flags;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [16:0] length;
    logic [63:0] saddr_hi;
    logic [63:0] saddr_lo;
    logic [63:0] daddr_hi;
    logic [63:0] daddr_lo;
    logic [31:0] port_tag;
  } rec_t;

endpackage

// ===== rtl/packet_flow_header_parser.sv =====
// packet_flow_header_parser: input byte register, parse core and flow record register
// depends on fph_pkg and fph_parse
// the record register loads as a frame's last byte leaves the input register
// throughput: one byte per cycle; a frame's last byte waits in the input register
// while the previous record is still stalled
// reset: asynchronous, active low; clears parse state, port_id and both valid flags
module packet_flow_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        port_id_we_i,
  input  logic [31:0] port_id_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  parse_status_o,
  output logic [2:0]  ip_family_o,
  output logic [7:0]  l4_protocol_o,
  output logic [7:0]  tcp_flag_bits_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [16:0] ip_length_o,
  output logic [63:0] source_addr_high_o,
  output logic [63:0] source_addr_low_o,
  output logic [63:0] dest_addr_high_o,
  output logic [63:0] dest_addr_low_o,
  output logic [31:0] port_tag_o
);

  logic          in_v_q;
  logic [7:0]    byte_q;
  logic          end_q;
  logic          out_v_q;
  fph_pkg::rec_t out_q;
  fph_pkg::rec_t rec;
  logic [31:0]   port_id_q;
  logic          advance;
  logic          load;

  // byte moves on unless it closes a frame while the record register is blocked
  assign advance    = in_v_q && !(end_q && out_v_q && out_stall_i);
  assign in_stall_o = in_v_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  fph_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (byte_q),
    .last_i    (end_q),
    .port_id_i (port_id_q),
    .rec_o     (rec)
  );

  // input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (load) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= frame_byte_i;
      end_q  <= frame_end_i;
    end
  end

  // interface number register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_id_q <= '0;
    end else if (port_id_we_i) begin
      port_id_q <= port_id_i;
    end
  end

  // flow record register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance && end_q) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && end_q) out_q <= rec;
  end

  assign out_valid_o        = out_v_q;
  assign parse_status_o     = out_q.status;
  assign ip_family_o        = out_q.family;
  assign l4_protocol_o      = out_q.proto;
  assign tcp_flag_bits_o    = out_q.flags;
  assign source_port_o      = out_q.sport;
  assign dest_port_o        = out_q.dport;
  assign ip_length_o        = out_q.length;
  assign source_addr_high_o = out_q.saddr_hi;
  assign source_addr_low_o  = out_q.saddr_lo;
  assign dest_addr_high_o   = out_q.daddr_hi;
  assign dest_addr_low_o    = out_q.daddr_lo;
  assign port_tag_o         = out_q.port_tag;

endmodule

// ===== rtl/fph_parse.sv =====
// fph_parse: running header parse state, one byte per step, and the flow record
// built when the last byte of a frame arrives; depends on fph_pkg
module fph_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic [31:0]   port_id_i,
  output fph_pkg::rec_t rec_o
);

  typedef enum logic [3:0] {
    PH_ETH, PH_TAG, PH_V4, PH_V6, PH_FRAG, PH_EXT, PH_TCP, PH_UDP, PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e      ph;
    logic [16:0] start;
    logic [5:0]  size;
    logic [1:0]  verdict;
  } disp_t;

  function automatic logic [16:0] room(input logic [16:0] cur, input logic [16:0] ie);
    return (cur >= ie) ? 17'd0 : ie - cur;
  endfunction

  function automatic logic is_ext(input logic [7:0] p);
    return p == fph_pkg::PROTO_HOPOPT || p == fph_pkg::PROTO_ROUTE ||
           p == fph_pkg::PROTO_FRAG || p == fph_pkg::PROTO_AH ||
           p == fph_pkg::PROTO_DSTOPT;
  endfunction

  function automatic disp_t go(input phase_e ph, input logic [16:0] st,
                               input logic [5:0] sz);
    disp_t d;
    d.ph = ph;
    d.start = st;
    d.size = sz;
    d.verdict = fph_pkg::ST_OK;
    return d;
  endfunction

  function automatic disp_t fin(input logic [1:0] v);
    disp_t d;
    d.ph = PH_DONE;
    d.start = 17'd0;
    d.size = 6'd0;
    d.verdict = v;
    return d;
  endfunction

  function automatic disp_t l2(input logic [15:0] nt, input logic [1:0] tags,
                               input logic [16:0] off);
    disp_t d;
    if ((nt == fph_pkg::ETH_VLAN || nt == fph_pkg::ETH_QINQ) &&
        tags < fph_pkg::MAX_VLAN_TAGS) d = go(PH_TAG, off, 6'd4);
    else if (nt == fph_pkg::ETH_IPV4) d = go(PH_V4, off, 6'd20);
    else if (nt == fph_pkg::ETH_IPV6) d = go(PH_V6, off, 6'd40);
    else d = fin(fph_pkg::ST_UNSUP);
    return d;
  endfunction

  function automatic disp_t transport(input logic [16:0] cur, input logic [7:0] p,
                                      input logic [16:0] ie);
    disp_t d;
    if (p == fph_pkg::PROTO_TCP) begin
      d = (room(cur, ie) < 17'd14) ? fin(fph_pkg::ST_ERR) : go(PH_TCP, cur, 6'd14);
    end else if (p == fph_pkg::PROTO_UDP) begin
      d = (room(cur, ie) < 17'd8) ? fin(fph_pkg::ST_ERR) : go(PH_UDP, cur, 6'd8);
    end else begin
      d = fin(fph_pkg::ST_OK);
    end
    return d;
  endfunction

  function automatic disp_t ext_disp(input logic [16:0] cur, input logic [7:0] p,
                                     input logic [2:0] cnt, input logic [16:0] ie);
    disp_t d;
    if (is_ext(p) && cnt < fph_pkg::MAX_EXT_HEADERS) begin
      if (p == fph_pkg::PROTO_FRAG)
        d = (room(cur, ie) < 17'd8) ? fin(fph_pkg::ST_ERR) : go(PH_FRAG, cur, 6'd8);
      else
        d = (room(cur, ie) < 17'd2) ? fin(fph_pkg::ST_ERR) : go(PH_EXT, cur, 6'd2);
    end else if (is_ext(p)) begin
      d = fin(fph_pkg::ST_UNSUP);
    end else begin
      d = transport(cur, p, ie);
    end
    return d;
  endfunction

  // state registers
  phase_e      phase_q, phase_d;
  logic [16:0] pos_q, pos_d;
  logic [15:0] ntype_q, ntype_d;
  logic [16:0] hstart_q;
  logic [5:0]  hsize_q;
  logic [16:0] ip_end_q, ip_end_d;
  logic [1:0]  tag_cnt_q, tag_cnt_d;
  logic [2:0]  ext_cnt_q, ext_cnt_d;
  logic [63:0] addr_q [4];
  logic [63:0] addr_d [4];
  logic [2:0]  family_q, family_d;
  logic [7:0]  proto_q, proto_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [16:0] length_q, length_d;
  logic [1:0]  verdict_q;
  logic [7:0]  cap_q [40];
  logic [7:0]  cap_d [40];

  disp_t       disp;
  logic        hdone;
  logic        capt;
  logic [16:0] diff;
  logic [5:0]  off;
  logic [5:0]  hl;
  logic [15:0] tl;
  logic [11:0] elen;
  logic [1:0]  status;

  // capture the byte and run the header step when a header completes
  always_comb begin
    pos_d     = (pos_q != fph_pkg::POS_MAX) ? pos_q + 17'd1 : pos_q;
    phase_d   = phase_q;
    ntype_d   = ntype_q;
    ip_end_d  = ip_end_q;
    tag_cnt_d = tag_cnt_q;
    ext_cnt_d = ext_cnt_q;
    addr_d    = addr_q;
    family_d  = family_q;
    proto_d   = proto_q;
    flags_d   = flags_q;
    sport_d   = sport_q;
    dport_d   = dport_q;
    length_d  = length_q;
    cap_d     = cap_q;
    disp      = go(phase_q, hstart_q, hsize_q);
    disp.verdict = verdict_q;
    hl   = 6'd0;
    tl   = 16'd0;
    elen = 12'd0;

    diff  = pos_q - hstart_q;
    off   = diff[5:0];
    capt  = (phase_q != PH_DONE) && (pos_q >= hstart_q) && (diff < {11'd0, hsize_q});
    hdone = capt && (off == hsize_q - 6'd1);
    if (capt) cap_d[off] = byte_i;

    if (hdone) begin
      case (phase_q)
        PH_ETH: begin
          ntype_d = {cap_d[12], cap_d[13]};
          disp = l2(ntype_d, tag_cnt_q, 17'd14);
        end
        PH_TAG: begin
          ntype_d = {cap_d[2], cap_d[3]};
          tag_cnt_d = tag_cnt_q + 2'd1;
          disp = l2(ntype_d, tag_cnt_d, hstart_q + 17'd4);
        end
        PH_V4: begin
          hl = {cap_d[0][3:0], 2'b00};
          tl = {cap_d[2], cap_d[3]};
          if (cap_d[0][7:4] != 4'd4 || hl < 6'd20 || tl < {10'd0, hl}) begin
            disp = fin(fph_pkg::ST_ERR);
          end else begin
            ip_end_d = hstart_q + {1'b0, tl};
            family_d = 3'd4;
            length_d = {1'b0, tl};
            addr_d[1] = {32'd0, cap_d[12], cap_d[13], cap_d[14], cap_d[15]};
            addr_d[3] = {32'd0, cap_d[16], cap_d[17], cap_d[18], cap_d[19]};
            proto_d = cap_d[9];
            if (({cap_d[6], cap_d[7]} & fph_pkg::V4_FRAG_MASK) != 16'd0)
              disp = fin(fph_pkg::ST_OK);
            else
              disp = transport(hstart_q + {11'd0, hl}, cap_d[9], ip_end_d);
          end
        end
        PH_V6: begin
          tl = {cap_d[4], cap_d[5]};
          if (cap_d[0][7:4] != 4'd6) begin
            disp = fin(fph_pkg::ST_ERR);
          end else if (tl == 16'd0) begin
            disp = fin(fph_pkg::ST_UNSUP);
          end else begin
            ip_end_d = hstart_q + 17'd40 + {1'b0, tl};
            family_d = 3'd6;
            length_d = 17'd40 + {1'b0, tl};
            for (int i = 0; i < 4; i++) begin
              addr_d[i] = {cap_d[8+8*i], cap_d[9+8*i], cap_d[10+8*i], cap_d[11+8*i],
                           cap_d[12+8*i], cap_d[13+8*i], cap_d[14+8*i], cap_d[15+8*i]};
            end
            ntype_d = {8'd0, cap_d[6]};
            if (!is_ext(cap_d[6])) proto_d = cap_d[6];
            disp = ext_disp(hstart_q + 17'd40, cap_d[6], ext_cnt_q, ip_end_d);
          end
        end
        PH_FRAG: begin
          ext_cnt_d = ext_cnt_q + 3'd1;
          if (({cap_d[2], cap_d[3]} & fph_pkg::V6_FRAG_MASK) != 16'd0) begin
            proto_d = cap_d[0];
            disp = fin(fph_pkg::ST_OK);
          end else begin
            ntype_d = {8'd0, cap_d[0]};
            if (!is_ext(cap_d[0])) proto_d = cap_d[0];
            disp = ext_disp(hstart_q + 17'd8, cap_d[0], ext_cnt_d, ip_end_q);
          end
        end
        PH_EXT: begin
          if (ntype_q == {8'd0, fph_pkg::PROTO_AH})
            elen = ({4'd0, cap_d[1]} + 12'd2) << 2;
          else
            elen = ({4'd0, cap_d[1]} + 12'd1) << 3;
          if (elen < 12'd8 || {5'd0, elen} > room(hstart_q, ip_end_q)) begin
            disp = fin(fph_pkg::ST_ERR);
          end else begin
            ext_cnt_d = ext_cnt_q + 3'd1;
            ntype_d = {8'd0, cap_d[0]};
            if (!is_ext(cap_d[0])) proto_d = cap_d[0];
            disp = ext_disp(hstart_q + {5'd0, elen}, cap_d[0], ext_cnt_d, ip_end_q);
          end
        end
        PH_TCP: begin
          hl = {cap_d[12][7:4], 2'b00};
          if (hl < 6'd20 || {11'd0, hl} > room(hstart_q, ip_end_q)) begin
            disp = fin(fph_pkg::ST_ERR);
          end else begin
            sport_d = {cap_d[0], cap_d[1]};
            dport_d = {cap_d[2], cap_d[3]};
            flags_d = cap_d[13];
            disp = fin(fph_pkg::ST_OK);
          end
        end
        PH_UDP: begin
          tl = {cap_d[4], cap_d[5]};
          if (tl < 16'd8 || {1'b0, tl} > room(hstart_q, ip_end_q)) begin
            disp = fin(fph_pkg::ST_ERR);
          end else begin
            sport_d = {cap_d[0], cap_d[1]};
            dport_d = {cap_d[2], cap_d[3]};
            disp = fin(fph_pkg::ST_OK);
          end
        end
        default: begin
          disp = fin(fph_pkg::ST_ERR);
        end
      endcase
    end
    phase_d = disp.ph;
  end

  // final verdict, with the frame length check
  always_comb begin
    if (phase_d != PH_DONE) status = fph_pkg::ST_ERR;
    else if (disp.verdict != fph_pkg::ST_ERR && pos_d < ip_end_d) status = fph_pkg::ST_ERR;
    else status = disp.verdict;

    rec_o = '0;
    rec_o.status = status;
    if (status == fph_pkg::ST_OK) begin
      rec_o.family   = family_d;
      rec_o.proto    = proto_d;
      rec_o.flags    = flags_d;
      rec_o.sport    = sport_d;
      rec_o.dport    = dport_d;
      rec_o.length   = length_d;
      rec_o.saddr_hi = addr_d[0];
      rec_o.saddr_lo = addr_d[1];
      rec_o.daddr_hi = addr_d[2];
      rec_o.daddr_lo = addr_d[3];
      rec_o.port_tag = port_id_i;
    end
  end

  // header capture bytes
  always_ff @(posedge clk_i) begin
    if (step_i) cap_q <= cap_d;
  end

  // parse state, cleared at reset and after each frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_ETH;
      pos_q     <= '0;
      ntype_q   <= '0;
      hstart_q  <= '0;
      hsize_q   <= 6'd14;
      ip_end_q  <= '0;
      tag_cnt_q <= '0;
      ext_cnt_q <= '0;
      for (int i = 0; i < 4; i++) addr_q[i] <= '0;
      family_q  <= '0;
      proto_q   <= '0;
      flags_q   <= '0;
      sport_q   <= '0;
      dport_q   <= '0;
      length_q  <= '0;
      verdict_q <= fph_pkg::ST_OK;
    end else if (step_i) begin
      if (last_i) begin
        phase_q   <= PH_ETH;
        pos_q     <= '0;
        ntype_q   <= '0;
        hstart_q  <= '0;
        hsize_q   <= 6'd14;
        ip_end_q  <= '0;
        tag_cnt_q <= '0;
        ext_cnt_q <= '0;
        for (int i = 0; i < 4; i++) addr_q[i] <= '0;
        family_q  <= '0;
        proto_q   <= '0;
        flags_q   <= '0;
        sport_q   <= '0;
        dport_q   <= '0;
        length_q  <= '0;
        verdict_q <= fph_pkg::ST_OK;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        ntype_q   <= ntype_d;
        hstart_q  <= disp.start;
        hsize_q   <= disp.size;
        ip_end_q  <= ip_end_d;
        tag_cnt_q <= tag_cnt_d;
        ext_cnt_q <= ext_cnt_d;
        addr_q    <= addr_d;
        family_q  <= family_d;
        proto_q   <= proto_d;
        flags_q   <= flags_d;
        sport_q   <= sport_d;
        dport_q   <= dport_d;
        length_q  <= length_d;
        verdict_q <= disp.verdict;
      end
    end
  end

endmodule
